@@ rtl/ked_pkg.sv @@
// ----------------------------------------------------------------------------
// ked_pkg
// Shared widths, register map, event codes and controller/datapath types
// for the key event detector.
// ----------------------------------------------------------------------------
package ked_pkg;

    // Key code and hold counter widths
    localparam int KEY_BITS   = 8;
    localparam int COUNT_BITS = 16;

    // Configuration field widths
    localparam int DOWN_BITS = 8;
    localparam int TICK_BITS = 16;

    // Width that holds both the counter and any tick threshold
    localparam int CMP_BITS = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;
    // Width of the wrap reload sum before truncation
    localparam int SUM_BITS = (COUNT_BITS > TICK_BITS + 1) ? COUNT_BITS : TICK_BITS + 1;
    // Bit counter of the remainder unit
    localparam int DIV_CNT_BITS = $clog2(COUNT_BITS + 1);

    // APB register port
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // Register indexes (byte address 4*index)
    typedef enum logic [1:0] {
        REG_DOWN_TICKS   = 2'd0,
        REG_PSTART_TICKS = 2'd1,
        REG_PSTEP_TICKS  = 2'd2,
        REG_DWIN_TICKS   = 2'd3
    } reg_index_t;

    // Register reset values
    localparam logic [DOWN_BITS-1:0] DOWN_TICKS_RST   = 8'd2;
    localparam logic [TICK_BITS-1:0] PSTART_TICKS_RST = 16'd100;
    localparam logic [TICK_BITS-1:0] PSTEP_TICKS_RST  = 16'd20;
    localparam logic [TICK_BITS-1:0] DWIN_TICKS_RST   = 16'd30;

    // Event codes
    typedef enum logic [2:0] {
        EV_DOWN    = 3'd0,
        EV_DOUBLE  = 3'd1,
        EV_PSTART  = 3'd2,
        EV_REPEAT  = 3'd3,
        EV_LONGUP  = 3'd4,
        EV_SHORTUP = 3'd5
    } ev_kind_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [DOWN_BITS-1:0] down_ticks;
        logic [TICK_BITS-1:0] press_start_ticks;
        logic [TICK_BITS-1:0] press_step_ticks;
        logic [TICK_BITS-1:0] double_window_ticks;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_key;
        logic commit;
        logic div_start;
        logic div_step;
        logic out_load;
        logic out_repeat;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic has_event;
        logic div_done;
        logic rem_zero;
    } dp_status_t;

endpackage

@@ rtl/ked_if.sv @@
// ----------------------------------------------------------------------------
// ked_if
// Valid/ready channel interfaces: scan ticks in, key events out.
// ----------------------------------------------------------------------------
interface ked_key_if
    import ked_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

interface ked_event_if
    import ked_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [2:0]          event_kind;
    logic [KEY_BITS-1:0] event_key;

    modport source (output valid, output event_kind, output event_key, input ready);
    modport sink   (input valid, input event_kind, input event_key, output ready);
endinterface

@@ rtl/ked_cfg.sv @@
// ----------------------------------------------------------------------------
// ked_cfg
// APB register bank holding the tick thresholds.
// ----------------------------------------------------------------------------
module ked_cfg
    import ked_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Update registers on the APB access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.down_ticks          <= DOWN_TICKS_RST;
            cfg_reg.press_start_ticks   <= PSTART_TICKS_RST;
            cfg_reg.press_step_ticks    <= PSTEP_TICKS_RST;
            cfg_reg.double_window_ticks <= DWIN_TICKS_RST;
        end
        else if (wr_en)
        begin
            case (index)
                REG_DOWN_TICKS:   cfg_reg.down_ticks          <= pwdata[DOWN_BITS-1:0];
                REG_PSTART_TICKS: cfg_reg.press_start_ticks   <= pwdata[TICK_BITS-1:0];
                REG_PSTEP_TICKS:  cfg_reg.press_step_ticks    <= pwdata[TICK_BITS-1:0];
                REG_DWIN_TICKS:   cfg_reg.double_window_ticks <= pwdata[TICK_BITS-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (index)
            REG_DOWN_TICKS:   prdata = DATA_BITS'(cfg_reg.down_ticks);
            REG_PSTART_TICKS: prdata = DATA_BITS'(cfg_reg.press_start_ticks);
            REG_PSTEP_TICKS:  prdata = DATA_BITS'(cfg_reg.press_step_ticks);
            REG_DWIN_TICKS:   prdata = DATA_BITS'(cfg_reg.double_window_ticks);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ rtl/ked_ctrl.sv @@
// ----------------------------------------------------------------------------
// ked_ctrl
// Sequencer: takes a tick, evaluates it, runs the repeat remainder check
// when needed and loads the output register.
// ----------------------------------------------------------------------------
module ked_ctrl
    import ked_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_key = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.need_div)
                begin
                    cmd.commit    = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (status.has_event)
                begin
                    // hold the tick until the output register is free
                    if (slot_free)
                    begin
                        cmd.commit   = 1'b1;
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (!status.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (!status.rem_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_repeat = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Set the output valid on load, drop it when the request is taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/ked_dp.sv @@
// ----------------------------------------------------------------------------
// ked_dp
// Datapath: key and hold state, threshold decisions, bit-serial remainder
// unit for the repeat step and the output register.
// ----------------------------------------------------------------------------
module ked_dp
    import ked_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  dp_cmd_t             cmd,
    input  logic [KEY_BITS-1:0] key_code,
    output dp_status_t          status,
    output ev_kind_t            event_kind,
    output logic [KEY_BITS-1:0] event_key
);

    // Tick and state registers
    logic [KEY_BITS-1:0]     key_reg;
    logic [COUNT_BITS-1:0]   hold_count_reg;
    logic [COUNT_BITS-1:0]   hold_count_next;
    logic [KEY_BITS-1:0]     previous_key_reg;
    logic [KEY_BITS-1:0]     previous_key_next;
    logic [KEY_BITS-1:0]     double_key_reg;
    logic [KEY_BITS-1:0]     double_key_next;
    logic [TICK_BITS-1:0]    double_remaining_reg;
    logic [TICK_BITS-1:0]    double_remaining_next;

    // Remainder unit
    logic [COUNT_BITS-1:0]   div_dvd_reg;
    logic [TICK_BITS-1:0]    div_rem_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic [TICK_BITS:0]      div_trial;
    logic [TICK_BITS:0]      div_sub;

    // Output register
    ev_kind_t                out_kind_reg;
    logic [KEY_BITS-1:0]     out_key_reg;

    // Evaluation terms
    logic [COUNT_BITS-1:0]   hold_inc;
    logic [TICK_BITS-1:0]    dr_dec;
    logic                    key_match;
    logic [CMP_BITS-1:0]     hold_inc_x;
    logic [CMP_BITS-1:0]     hold_x;
    logic [CMP_BITS-1:0]     down_x;
    logic [CMP_BITS-1:0]     start_x;
    logic [CMP_BITS-1:0]     over_start;
    logic [SUM_BITS-1:0]     reload_sum;
    logic                    ev_valid;
    ev_kind_t                ev_kind;
    logic [KEY_BITS-1:0]     ev_key;
    logic                    need_div;

    assign hold_inc   = hold_count_reg + COUNT_BITS'(1);
    assign dr_dec     = (double_remaining_reg != '0) ?
                        double_remaining_reg - TICK_BITS'(1) : '0;
    assign key_match  = (key_reg != '0) && (key_reg == previous_key_reg);
    assign hold_inc_x = CMP_BITS'(hold_inc);
    assign hold_x     = CMP_BITS'(hold_count_reg);
    assign down_x     = CMP_BITS'(cfg.down_ticks);
    assign start_x    = CMP_BITS'(cfg.press_start_ticks);
    assign over_start = hold_inc_x - start_x;
    assign reload_sum = SUM_BITS'(cfg.press_start_ticks) + SUM_BITS'(cfg.press_step_ticks);

    // Decide the next state and the event of this tick
    always_comb
    begin
        hold_count_next       = hold_count_reg;
        previous_key_next     = previous_key_reg;
        double_key_next       = double_key_reg;
        double_remaining_next = dr_dec;
        ev_valid              = 1'b0;
        ev_kind               = EV_DOWN;
        ev_key                = key_reg;
        need_div              = 1'b0;
        if (key_match)
        begin
            hold_count_next = hold_inc;
            if (hold_inc == '0)
            begin
                // counter wrapped: reload past the press start
                hold_count_next = reload_sum[COUNT_BITS-1:0];
            end
            else if (hold_inc_x == down_x)
            begin
                ev_valid = 1'b1;
                if (dr_dec == '0)
                begin
                    double_key_next       = previous_key_reg;
                    double_remaining_next = cfg.double_window_ticks;
                end
                else if (double_key_reg == previous_key_reg)
                begin
                    double_key_next       = '0;
                    double_remaining_next = '0;
                    ev_kind               = EV_DOUBLE;
                end
            end
            else if (hold_inc_x == start_x)
            begin
                ev_valid = 1'b1;
                ev_kind  = EV_PSTART;
            end
            else if (hold_inc_x > start_x)
            begin
                need_div = (cfg.press_step_ticks != '0);
            end
        end
        else
        begin
            hold_count_next = '0;
            if (hold_x >= start_x)
            begin
                ev_valid = 1'b1;
                ev_kind  = EV_LONGUP;
                ev_key   = previous_key_reg;
            end
            else if (hold_x >= down_x)
            begin
                ev_valid = 1'b1;
                ev_kind  = EV_SHORTUP;
                ev_key   = previous_key_reg;
            end
            else
            begin
                previous_key_next = key_reg;
            end
        end
    end

    // Restoring remainder step: shift in one dividend bit, subtract if it fits
    assign div_trial = {div_rem_reg, div_dvd_reg[COUNT_BITS-1]};
    assign div_sub   = div_trial - {1'b0, cfg.press_step_ticks};

    // Capture the tick
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
            key_reg <= key_code;
    end

    // Commit the tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg       <= '0;
            previous_key_reg     <= '0;
            double_key_reg       <= '0;
            double_remaining_reg <= '0;
        end
        else if (cmd.commit)
        begin
            hold_count_reg       <= hold_count_next;
            previous_key_reg     <= previous_key_next;
            double_key_reg       <= double_key_next;
            double_remaining_reg <= double_remaining_next;
        end
    end

    // Advance the remainder unit one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= DIV_CNT_BITS'(COUNT_BITS);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - DIV_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_dvd_reg <= over_start[COUNT_BITS-1:0];
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_dvd_reg <= {div_dvd_reg[COUNT_BITS-2:0], 1'b0};
            if (div_trial >= {1'b0, cfg.press_step_ticks})
                div_rem_reg <= div_sub[TICK_BITS-1:0];
            else
                div_rem_reg <= div_trial[TICK_BITS-1:0];
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_repeat ? EV_REPEAT : ev_kind;
            out_key_reg  <= cmd.out_repeat ? key_reg : ev_key;
        end
    end

    assign status.need_div  = need_div;
    assign status.has_event = ev_valid;
    assign status.div_done  = (div_cnt_reg == '0);
    assign status.rem_zero  = (div_rem_reg == '0);
    assign event_kind       = out_kind_reg;
    assign event_key        = out_key_reg;

endmodule

@@ rtl/key_event_detector.sv @@
// ----------------------------------------------------------------------------
// key_event_detector
// Debounced key scan with key down, double click, long press, press repeat
// and release events.
// ----------------------------------------------------------------------------
// Usage:
//   key_in carries one scan tick per request: the key code seen on that tick,
//   zero meaning no key. event_out carries at most one event per tick: its
//   kind (down, double click, press start, press repeat, long up, short up)
//   and the key it refers to. Thresholds are set over the APB port at byte
//   addresses 0, 4, 8 and 12; the user must write them only while no tick is
//   in flight, as the block itself does not enforce this. A tick is captured
//   and then evaluated; when the hold count has passed the press start
//   threshold and the repeat step must be checked, the remainder unit first
//   retires one dividend bit per cycle. One tick is in flight at a time.
//   Events sit in an output register, so the next tick is accepted while an
//   event waits; a tick with an event of its own then waits until that
//   register is taken. Reset clears the hold state, the double-click window
//   and the output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module key_event_detector
    import ked_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ked_key_if.sink              key_in,
    ked_event_if.source          event_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;
    ev_kind_t   event_kind;

    ked_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ked_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (key_in.valid),
        .in_ready  (key_in.ready),
        .out_valid (event_out.valid),
        .out_ready (event_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ked_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .key_code   (key_in.key_code),
        .status     (status),
        .event_kind (event_kind),
        .event_key  (event_out.event_key)
    );

    assign event_out.event_kind = event_kind;

    // A tick is taken only when nothing else is in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        key_in.valid && key_in.ready |=> !key_in.ready)
        else $error("tick accepted while another tick is in flight");

    // Only defined event codes leave the block
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        event_out.valid |-> event_out.event_kind <= EV_SHORTUP)
        else $error("undefined event kind on output");

    // An output load never overwrites an event that is not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !event_out.valid || event_out.ready)
        else $error("event overwritten before it was taken");

endmodule

@@ tb/key_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_checker
// Watches the scan tick and event channels and the APB port of the key event
// detector. It keeps its own copy of the thresholds and of the hold and
// double-click state, predicts the event of every accepted scan tick and
// compares each accepted event with the oldest prediction. Register reads
// are checked against the tracked register values.
// ----------------------------------------------------------------------------
module key_event_checker
    import ked_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ked_key_if                   key_mon,
    ked_event_if                 event_mon,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    input  logic [DATA_BITS-1:0] prdata,
    output int                   error_count,
    output int                   pending,
    output int                   events_checked,
    output logic [5:0]           kinds_seen
);

    typedef struct packed {
        ev_kind_t            kind;
        logic [KEY_BITS-1:0] key;
    } key_event_t;

    // Thresholds as last written over APB
    logic [DOWN_BITS-1:0]  down_thr;
    logic [TICK_BITS-1:0]  start_thr;
    logic [TICK_BITS-1:0]  step_len;
    logic [TICK_BITS-1:0]  window_len;

    // Hold and double-click state
    logic [COUNT_BITS-1:0] held_ticks;
    logic [KEY_BITS-1:0]   last_key;
    logic [KEY_BITS-1:0]   click_key;
    logic [15:0]           click_left;

    // Events predicted but not yet taken from the output
    key_event_t            expected_events[$];

    key_event_t            want;
    key_event_t            next_event;
    bit                    fired;
    logic [DATA_BITS-1:0]  reg_value;

    // Advance the key state by one scan tick and report its event, if any
    task automatic scan_tick(input logic [KEY_BITS-1:0] code, output bit hit,
                             output key_event_t ev);
        hit = 1'b0;
        ev  = '0;
        if (click_left != 0)
            click_left = click_left - 1'b1;

        if (code != 0 && code == last_key) begin
            held_ticks = held_ticks + 1'b1;
            if (held_ticks == 0) begin
                // counter wrapped: reload past the press start, no event
                held_ticks = COUNT_BITS'(SUM_BITS'(start_thr) + SUM_BITS'(step_len));
            end
            else if (held_ticks == down_thr) begin
                hit    = 1'b1;
                ev.key = code;
                if (click_left == 0) begin
                    click_key  = last_key;
                    click_left = window_len;
                    ev.kind    = EV_DOWN;
                end
                else if (click_key == last_key) begin
                    click_key  = '0;
                    click_left = '0;
                    ev.kind    = EV_DOUBLE;
                end
                else begin
                    ev.kind = EV_DOWN;
                end
            end
            else if (held_ticks == start_thr) begin
                hit = 1'b1;
                ev  = '{EV_PSTART, code};
            end
            else if (held_ticks > start_thr) begin
                if (step_len != 0 && ((held_ticks - start_thr) % step_len) == 0) begin
                    hit = 1'b1;
                    ev  = '{EV_REPEAT, code};
                end
            end
        end
        else begin
            // key changed or released: report how long it was held
            if (held_ticks >= start_thr) begin
                hit = 1'b1;
                ev  = '{EV_LONGUP, last_key};
            end
            else if (held_ticks >= down_thr) begin
                hit = 1'b1;
                ev  = '{EV_SHORTUP, last_key};
            end
            held_ticks = '0;
        end

        // a tick with an event leaves the previous key alone
        if (!hit)
            last_key = code;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            down_thr       = DOWN_TICKS_RST;
            start_thr      = PSTART_TICKS_RST;
            step_len       = PSTEP_TICKS_RST;
            window_len     = DWIN_TICKS_RST;
            held_ticks     = '0;
            last_key       = '0;
            click_key      = '0;
            click_left     = '0;
            expected_events.delete();
            error_count    = 0;
            events_checked = 0;
            kinds_seen     = '0;
            pending       <= 0;
        end
        else begin
            // Compare a taken event against the oldest prediction
            if (event_mon.valid && event_mon.ready) begin
                events_checked++;
                if (expected_events.size() == 0) begin
                    error_count++;
                    $display("[%0t] event mismatch: expected none, got kind %0d key %02h",
                             $time, event_mon.event_kind, event_mon.event_key);
                end
                else begin
                    want = expected_events.pop_front();
                    if (event_mon.event_kind !== want.kind ||
                        event_mon.event_key !== want.key) begin
                        error_count++;
                        $display("[%0t] event mismatch: expected kind %0d key %02h, got kind %0d key %02h",
                                 $time, want.kind, want.key,
                                 event_mon.event_kind, event_mon.event_key);
                    end
                    else begin
                        kinds_seen[want.kind] = 1'b1;
                    end
                end
            end

            // Predict the event of an accepted scan tick
            if (key_mon.valid && key_mon.ready) begin
                scan_tick(key_mon.key_code, fired, next_event);
                if (fired)
                    expected_events.push_back(next_event);
            end

            // Track register writes, check register reads
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (reg_index_t'(paddr[3:2]))
                        REG_DOWN_TICKS:   down_thr   = pwdata[DOWN_BITS-1:0];
                        REG_PSTART_TICKS: start_thr  = pwdata[TICK_BITS-1:0];
                        REG_PSTEP_TICKS:  step_len   = pwdata[TICK_BITS-1:0];
                        REG_DWIN_TICKS:   window_len = pwdata[TICK_BITS-1:0];
                        default: ;
                    endcase
                end
                else begin
                    case (reg_index_t'(paddr[3:2]))
                        REG_DOWN_TICKS:   reg_value = DATA_BITS'(down_thr);
                        REG_PSTART_TICKS: reg_value = DATA_BITS'(start_thr);
                        REG_PSTEP_TICKS:  reg_value = DATA_BITS'(step_len);
                        default:          reg_value = DATA_BITS'(window_len);
                    endcase
                    if (prdata !== reg_value) begin
                        error_count++;
                        $display("[%0t] register %0d readback: expected %08h, got %08h",
                                 $time, paddr[3:2], reg_value, prdata);
                    end
                end
            end

            pending <= expected_events.size();
        end
    end

endmodule

@@ tb/key_event_detector_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_detector_tb
// Drives scan ticks and register settings into the key event detector while
// the checker beside it predicts and compares every event. A short directed
// run covers down, double click, press start, repeat and both release kinds;
// random press sequences then run under several threshold settings, zero and
// maximum values among them, with random gaps and output stalls. A final
// quiet stretch runs random presses with no gaps and no output stalls.
// ----------------------------------------------------------------------------
module key_event_detector_tb;
    import ked_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    ked_key_if   key_bus ();
    ked_event_if event_bus ();

    int          error_count;
    int          pending;
    int          events_checked;
    logic [5:0]  kinds_seen;

    // Stimulus shaping
    int                  ticks_sent;
    int                  settings_used;
    int                  gap_pct;
    int                  stall_pct;
    int                  stall_left;
    bit                  quiet;
    int                  cur_down;
    int                  cur_start;
    int                  cur_step;
    logic [KEY_BITS-1:0] recent_key;

    key_event_detector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_in    (key_bus),
        .event_out (event_bus),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    key_event_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .key_mon        (key_bus),
        .event_mon      (event_bus),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .error_count    (error_count),
        .pending        (pending),
        .events_checked (events_checked),
        .kinds_seen     (kinds_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the event output in random bursts
    initial
    begin
        event_bus.ready = 1'b0;
        stall_left      = 0;
        forever
        begin
            @(posedge clk);
            if (quiet) begin
                event_bus.ready <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                event_bus.ready <= 1'b0;
            end
            else if ($urandom_range(1, 100) <= stall_pct) begin
                stall_left = $urandom_range(0, 11);
                event_bus.ready <= 1'b0;
            end
            else begin
                event_bus.ready <= 1'b1;
            end
        end
    end

    // One APB transfer: setup cycle, then access cycle
    task automatic apb_access(input reg_index_t idx, input logic wr,
                              input logic [DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write a register, with random junk above its width half the time
    task automatic write_reg(input reg_index_t idx, input int value, input int width);
        logic [DATA_BITS-1:0] data;
        data = $urandom_range(0, 1) ? DATA_BITS'($urandom) : '0;
        data = (data << width) | DATA_BITS'(value);
        apb_access(idx, 1'b1, data);
    endtask

    task automatic read_all_regs();
        for (int i = 0; i < 4; i++)
            apb_access(reg_index_t'(i), 1'b0, '0);
    endtask

    task automatic apply_settings(input int d, input int ps, input int st, input int w);
        write_reg(REG_DOWN_TICKS, d, DOWN_BITS);
        write_reg(REG_PSTART_TICKS, ps, TICK_BITS);
        write_reg(REG_PSTEP_TICKS, st, TICK_BITS);
        write_reg(REG_DWIN_TICKS, w, TICK_BITS);
        read_all_regs();
        cur_down  = d;
        cur_start = ps;
        cur_step  = st;
        settings_used++;
    endtask

    // Offer one scan tick, after an optional idle burst, and wait for the request
    task automatic send_tick(input logic [KEY_BITS-1:0] code);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(1, 100) <= gap_pct)
            gap = $urandom_range(1, 12);
        if (gap > 0) begin
            key_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_bus.valid    <= 1'b1;
        key_bus.key_code <= code;
        @(posedge clk);
        while (!key_bus.ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic hold_key(input logic [KEY_BITS-1:0] code, input int count);
        repeat (count) send_tick(code);
    endtask

    // Drop valid, drain every expected event, then cover the longest tick latency
    task automatic settle();
        key_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (COUNT_BITS + 8) @(posedge clk);
    endtask

    // One press: a key held for a length aimed at the thresholds, mostly then a release
    task automatic press_sequence();
        logic [KEY_BITS-1:0] code;
        int                  len;
        int                  span;
        int                  pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            // noise: a few unrelated codes
            repeat ($urandom_range(1, 4)) send_tick(KEY_BITS'($urandom_range(0, 255)));
        end
        else begin
            if (pick < 4 && recent_key != 0)
                code = recent_key;
            else
                code = KEY_BITS'($urandom_range(1, 255));
            span = 3 * cur_step + 3;
            if (span > 60)
                span = 60;
            case ($urandom_range(0, 3))
                0:       len = $urandom_range(1, cur_down + 2);
                1:       len = cur_down + $urandom_range(0, 2);
                default: len = cur_start + $urandom_range(0, span);
            endcase
            if (len < 1)
                len = 1;
            if (len > 400)
                len = $urandom_range(1, 40);
            // first tick only latches the key, unless that key is still the latched one
            hold_key(code, len + 1);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 3)) send_tick('0);
            recent_key = code;
        end
    endtask

    task automatic random_phase(input int count);
        int phase_start;
        phase_start = ticks_sent;
        while (ticks_sent - phase_start < count)
            press_sequence();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        key_bus.valid    = 1'b0;
        key_bus.key_code = '0;
        quiet            = 1'b0;
        gap_pct          = 0;
        stall_pct        = 0;
        ticks_sent       = 0;
        settings_used    = 1;
        recent_key       = '0;
        cur_down         = int'(DOWN_TICKS_RST);
        cur_start        = int'(PSTART_TICKS_RST);
        cur_step         = int'(PSTEP_TICKS_RST);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values read back, then down, double click and short up
        read_all_regs();
        gap_pct   = 20;
        stall_pct = 20;
        hold_key(8'h01, 3);
        hold_key(8'h00, 2);
        hold_key(8'h01, 3);
        hold_key(8'h00, 2);
        hold_key(8'hFF, 3);
        hold_key(8'h00, 2);
        settle();

        // Tight thresholds: down, press start, repeats, long up on a direct key change, then down and short up
        apply_settings(1, 3, 2, 4);
        hold_key(8'h80, 8);
        hold_key(8'h7F, 3);
        hold_key(8'h00, 1);
        settle();

        // Random presses under a series of settings
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 30;
            endcase
            case (phase)
                0: apply_settings(1, 2, 1, 0);
                1: apply_settings(255, 256, 65535, 65535);
                2: apply_settings(0, 0, 0, 0);
                3: apply_settings(4, 2, 3, 10);
                4: apply_settings(0, 5, 0, 20);
                default:
                begin
                    cur_down = $urandom_range(1, 6);
                    apply_settings(cur_down, cur_down + $urandom_range(1, 20),
                                   $urandom_range(1, 8), $urandom_range(0, 40));
                end
            endcase
            random_phase(100);
            settle();
        end

        // Quiet tail: no gaps and no output stalls
        quiet = 1'b1;
        settle();
        cur_down = $urandom_range(1, 4);
        apply_settings(cur_down, cur_down + $urandom_range(1, 10),
                       $urandom_range(1, 4), $urandom_range(0, 20));
        random_phase(100);
        settle();

        $display("covered %0d scan ticks under %0d register settings, %0d events checked",
                 ticks_sent, settings_used, events_checked);
        $display("event kinds seen (short up .. down): %b", kinds_seen);
        if (pending != 0)
            $display("[%0t] %0d expected events never arrived", $time, pending);
        if (error_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Abort a run that hangs
    initial
    begin
        #50_000_000;
        $display("[%0t] timeout with %0d events still expected", $time, pending);
        $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ked_pkg.sv
rtl/ked_if.sv
rtl/ked_cfg.sv
rtl/ked_ctrl.sv
rtl/ked_dp.sv
rtl/key_event_detector.sv
tb/key_event_checker.sv
tb/key_event_detector_tb.sv
